// ===== design/ufbu_pkg.sv =====
// ----------------------------------------------------------------------------
// UART frame bit unpacker package
// Shared widths, frame constants and the result type of the deframer.
// ----------------------------------------------------------------------------
package ufbu_pkg;

  localparam int unsigned ByteW            = 8;
  localparam int unsigned FrameBits        = 10;
  localparam int unsigned FrameCntW        = 4;
  localparam int unsigned SkipW            = 5;
  localparam int unsigned SyncSkipDefault  = 8;
  localparam int unsigned SyncSkipMax      = 16;

  typedef struct packed {
    logic             has_byte;
    logic [ByteW-1:0] data_byte;
    logic             frame_end;
    logic             framing_error;
    logic [ByteW-1:0] decoded_count;
  } res_t;

endpackage

// ===== design/ufbu_in_if.sv =====
// ----------------------------------------------------------------------------
// UART frame bit unpacker input channel
// Valid/ready channel that carries one received payload byte per item.
// ----------------------------------------------------------------------------
interface ufbu_in_if
  import ufbu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic             last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ===== design/ufbu_out_if.sv =====
// ----------------------------------------------------------------------------
// UART frame bit unpacker output channel
// Valid/ready channel that carries one decoded result per item.
// ----------------------------------------------------------------------------
interface ufbu_out_if
  import ufbu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             has_byte;
  logic [ByteW-1:0] data_byte;
  logic             frame_end;
  logic             framing_error;
  logic [ByteW-1:0] decoded_count;

  modport source (output valid, output has_byte, output data_byte, output frame_end,
                  output framing_error, output decoded_count, input ready);
  modport sink   (input valid, input has_byte, input data_byte, input frame_end,
                  input framing_error, input decoded_count, output ready);
endinterface

// ===== design/uart_frame_bit_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// UART frame bit unpacker
// Deframes 8N1 UART frames from a packed, MSB-first byte stream.
// ----------------------------------------------------------------------------
// The input channel takes one received byte per item together with a flag
// that marks the last byte of a buffer. After reset and after every last
// byte, the first SYNC_SKIP_BITS bits of the stream are dropped. The rest
// is cut into ten-bit frames of start bit, eight data bits sent LSB first,
// and stop bit. A good frame gives one data byte; the first bad frame
// stops decoding until the buffer ends.
// The output channel carries an item for every input item that completes
// a good frame or carries the last byte; other items give no output.
// One input item is taken per cycle while input ready is high. All eight
// bits are handled by one pass of combinational logic, so a result goes
// into the output register, or into the skid register while that is full.
// A two-entry output stage (output register plus skid register) keeps the
// input ready while one result waits; input ready drops only when both
// entries are full and stays low until the receiver takes an item.
// Reset restarts the decoder and empties the output stage.
// ----------------------------------------------------------------------------
module uart_frame_bit_unpacker_unit
  import ufbu_pkg::*;
#(
  parameter int unsigned SYNC_SKIP_BITS = SyncSkipDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ufbu_in_if.sink    in_i,
  ufbu_out_if.source out_o
);

  localparam logic [SkipW-1:0]     SkipInit = SkipW'(SYNC_SKIP_BITS);
  localparam logic [FrameCntW-1:0] LastBit  = FrameCntW'(FrameBits - 1);

  logic [FrameBits-2:0] shift_q, shift_d;
  logic [FrameCntW-1:0] cnt_q, cnt_d;
  logic [SkipW-1:0]     skip_q, skip_d;
  logic                 halt_q, halt_d;
  logic                 err_q, err_d;
  logic [ByteW-1:0]     count_q, count_d;

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  res_t                 out_q, out_d;
  res_t                 skid_q, skid_d;

  logic                 accept;
  logic                 pop;
  logic                 push;
  logic                 got;
  logic [ByteW-1:0]     data;
  res_t                 res;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_valid_q && out_o.ready;

  always_comb begin
    logic [FrameBits-2:0] sh;
    logic [FrameCntW-1:0] cnt;
    logic [SkipW-1:0]     skip;
    logic                 halt;
    logic                 err;
    logic [ByteW-1:0]     count;
    logic                 bit_v;
    sh    = shift_q;
    cnt   = cnt_q;
    skip  = skip_q;
    halt  = halt_q;
    err   = err_q;
    count = count_q;
    got   = 1'b0;
    data  = '0;
    for (int k = 0; k < ByteW; k++) begin
      bit_v = in_i.payload_byte[ByteW-1-k];
      if (!halt) begin
        if (skip != '0) begin
          skip = skip - 1'b1;
        end else if (cnt == LastBit) begin
          if (!sh[0] && bit_v) begin
            got  = 1'b1;
            data = sh[FrameBits-2:1];
            if (count != '1) begin
              count = count + 1'b1;
            end
          end else begin
            halt = 1'b1;
            err  = 1'b1;
          end
          cnt = '0;
        end else begin
          sh  = {bit_v, sh[FrameBits-2:1]};
          cnt = cnt + 1'b1;
        end
      end
    end

    res.has_byte      = got;
    res.data_byte     = data;
    res.frame_end     = in_i.last_byte;
    res.framing_error = err;
    res.decoded_count = count;
    push              = accept && (got || in_i.last_byte);

    shift_d = shift_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    halt_d  = halt_q;
    err_d   = err_q;
    count_d = count_q;
    if (accept) begin
      if (in_i.last_byte) begin
        shift_d = '0;
        cnt_d   = '0;
        skip_d  = SkipInit;
        halt_d  = 1'b0;
        err_d   = 1'b0;
        count_d = '0;
      end else begin
        shift_d = sh;
        cnt_d   = cnt;
        skip_d  = skip;
        halt_d  = halt;
        err_d   = err;
        count_d = count;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      skip_q       <= SkipInit;
      halt_q       <= 1'b0;
      err_q        <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      skip_q       <= skip_d;
      halt_q       <= halt_d;
      err_q        <= err_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    out_q   <= out_d;
    skid_q  <= skid_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.has_byte      = out_q.has_byte;
  assign out_o.data_byte     = out_q.data_byte;
  assign out_o.frame_end     = out_q.frame_end;
  assign out_o.framing_error = out_q.framing_error;
  assign out_o.decoded_count = out_q.decoded_count;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds an item while the output register is empty.");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastBit)
    else $error("Frame bit count exceeds the frame length.");

  a_halt_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> err_q)
    else $error("Decoder halted without a framing error.");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last_byte) |=>
      (cnt_q == '0) && !halt_q && !err_q && (count_q == '0) && (skip_q == SkipInit))
    else $error("Decoder state not cleared after the last byte.");
`endif

endmodule

// ===== bench/uart_frame_bit_unpacker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// UART frame bit unpacker testbench
// Sends buffers of packed MSB-first bytes that hold sync bits, 8N1 frames,
// broken frames and trailing bits. A scoreboard decodes the same stream
// and checks every output item, field by field and in order.
// ----------------------------------------------------------------------------
module uart_frame_bit_unpacker_unit_tb
  import ufbu_pkg::*;
();

  localparam int unsigned SkipBits   = SyncSkipDefault;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned ItemTarget = 1500;

  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_ZEROS,
    PAT_ONES
  } data_pat_e;

  class deframe_scoreboard;
    logic [FrameBits-1:0] frame_shift;
    logic [FrameCntW-1:0] frame_bits;
    logic [SkipW-1:0]     skip_left;
    logic                 halted;
    logic                 err_seen;
    logic [ByteW-1:0]     byte_total;
    res_t                 expected_results[$];
    int unsigned          errors;
    int unsigned          bytes_taken;
    int unsigned          results_seen;

    function new();
      errors       = 0;
      bytes_taken  = 0;
      results_seen = 0;
      clear_decoder();
    endfunction

    function void clear_decoder();
      frame_shift = '0;
      frame_bits  = '0;
      skip_left   = SkipW'(SkipBits);
      halted      = 1'b0;
      err_seen    = 1'b0;
      byte_total  = '0;
    endfunction

    function bit predict_deframe(input logic [ByteW-1:0] b, input logic l, output res_t r);
      logic             got;
      logic [ByteW-1:0] data;
      got  = 1'b0;
      data = '0;
      for (int k = ByteW - 1; k >= 0; k--) begin
        if (halted) break;
        if (skip_left != 0) begin
          skip_left--;
          continue;
        end
        frame_shift[frame_bits] = b[k];
        frame_bits++;
        if (frame_bits == FrameBits) begin
          if (!frame_shift[0] && frame_shift[FrameBits-1]) begin
            got  = 1'b1;
            data = frame_shift[ByteW:1];
            if (byte_total != 8'hFF) byte_total++;
          end else begin
            halted   = 1'b1;
            err_seen = 1'b1;
          end
          frame_shift = '0;
          frame_bits  = '0;
        end
      end
      r.has_byte      = got;
      r.data_byte     = got ? data : '0;
      r.frame_end     = l;
      r.framing_error = err_seen;
      r.decoded_count = byte_total;
      if (l) clear_decoder();
      return got || l;
    endfunction

    function void note_byte(input logic [ByteW-1:0] b, input logic l);
      res_t r;
      bytes_taken++;
      if (predict_deframe(b, l, r)) expected_results = {expected_results, r};
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch at output item %0d: %s", results_seen, msg);
    endtask

    task check_result(input res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report("output item with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (got.has_byte !== want.has_byte)
          report($sformatf("has_byte %b, expected %b", got.has_byte, want.has_byte));
        if (got.data_byte !== want.data_byte)
          report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
        if (got.frame_end !== want.frame_end)
          report($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
        if (got.framing_error !== want.framing_error)
          report($sformatf("framing_error %b, expected %b",
                           got.framing_error, want.framing_error));
        if (got.decoded_count !== want.decoded_count)
          report($sformatf("decoded_count %0d, expected %0d",
                           got.decoded_count, want.decoded_count));
      end
      results_seen++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   gaps_on = 1'b1;
  bit   stalls_on = 1'b1;
  int unsigned quiet_cycles = 0;
  deframe_scoreboard sb = new();

  ufbu_in_if  in_if();
  ufbu_out_if out_if();

  uart_frame_bit_unpacker_unit #(
    .SYNC_SKIP_BITS(SkipBits)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  task automatic push_byte(input logic [ByteW-1:0] b, input logic l);
    if (gaps_on && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    in_if.valid        <= 1'b1;
    in_if.payload_byte <= b;
    in_if.last_byte    <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, l);
    @(negedge clk_i);
  endtask

  task automatic send_frames(input int unsigned nframes, input int bad_at,
                             input int unsigned tail_bits, input data_pat_e pat);
    bit               bits[$];
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] b;
    bit               start_bit;
    bit               stop_bit;
    int unsigned      nbytes;
    for (int i = 0; i < SkipBits; i++) bits = {bits, 1'($urandom_range(1))};
    for (int f = 0; f < nframes; f++) begin
      case (pat)
        PAT_ZEROS: data = '0;
        PAT_ONES:  data = '1;
        default:   data = ByteW'($urandom);
      endcase
      start_bit = 1'b0;
      stop_bit  = 1'b1;
      if (f == bad_at) begin
        case ($urandom_range(2))
          0:       start_bit = 1'b1;
          1:       stop_bit = 1'b0;
          default: begin
            start_bit = 1'b1;
            stop_bit  = 1'b0;
          end
        endcase
      end
      bits = {bits, start_bit};
      for (int i = 0; i < ByteW; i++) bits = {bits, data[i]};
      bits = {bits, stop_bit};
    end
    for (int i = 0; i < tail_bits; i++) bits = {bits, 1'($urandom_range(1))};
    while (bits.size() == 0 || bits.size() % ByteW != 0) bits = {bits, 1'($urandom_range(1))};
    nbytes = bits.size() / ByteW;
    for (int i = 0; i < nbytes; i++) begin
      for (int j = 0; j < ByteW; j++) b[ByteW-1-j] = bits[i*ByteW+j];
      push_byte(b, i == nbytes - 1);
    end
  endtask

  task automatic send_noise(input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) push_byte(ByteW'($urandom), i == nbytes - 1);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_buffer();
    int unsigned nframes;
    int          bad_at;
    if ($urandom_range(99) < 20) begin
      send_noise($urandom_range(1, 6));
    end else begin
      nframes = $urandom_range(0, 12);
      bad_at  = -1;
      if (nframes != 0 && $urandom_range(99) < 30) bad_at = $urandom_range(nframes - 1);
      send_frames(nframes, bad_at, $urandom_range(0, FrameBits - 1), PAT_RANDOM);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !(stalls_on && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{has_byte:      out_if.has_byte,
                        data_byte:     out_if.data_byte,
                        frame_end:     out_if.frame_end,
                        framing_error: out_if.framing_error,
                        decoded_count: out_if.decoded_count});
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("uart_frame_bit_unpacker_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.payload_byte = '0;
    in_if.last_byte    = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    send_frames(4, -1, 0, PAT_ZEROS);
    send_frames(1, -1, 0, PAT_ONES);
    send_frames(3, 0, 0, PAT_RANDOM);
    send_frames(2, 1, 5, PAT_RANDOM);
    hold_until_drained();

    while (sb.bytes_taken < ItemTarget) begin
      if (sb.bytes_taken > ItemTarget / 3 && sb.bytes_taken < ItemTarget / 2) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
      end
      if (sb.bytes_taken > ItemTarget / 2 && sb.bytes_taken < ItemTarget / 2 + 40) begin
        send_frames(260, -1, $urandom_range(0, FrameBits - 1), PAT_RANDOM);
      end else begin
        send_random_buffer();
      end
      if ($urandom_range(99) < 4) hold_until_drained();
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("uart_frame_bit_unpacker_unit_tb: clean");
    end else begin
      $display("uart_frame_bit_unpacker_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ufbu_pkg.sv
design/ufbu_in_if.sv
design/ufbu_out_if.sv
design/uart_frame_bit_unpacker_unit.sv
bench/uart_frame_bit_unpacker_unit_tb.sv
